// ----- hdl/line_rasterizer_macros.svh -----
// Assertion macros for the line rasterizer checker.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Checked on every clock edge outside reset.
`define LR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("line rasterizer check failed");

// Checked on every clock edge, reset included.
`define LR_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("line rasterizer reset check failed");

`endif

// ----- hdl/lr_pkg.sv -----
// Shared constants and types for the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int STRIDE_W       = 12;
    localparam int OFFSET_W       = 22;
    localparam int COLOR_W        = 32;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd1920;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // bit 1: leftward, bit 0: shallow
    typedef enum logic [1:0] {
        OCT_STEEP_RIGHT   = 2'd0,
        OCT_SHALLOW_RIGHT = 2'd1,
        OCT_STEEP_LEFT    = 2'd2,
        OCT_SHALLOW_LEFT  = 2'd3
    } octant_t;

    typedef struct packed {
        logic valid;
        logic last;
    } pix_ctl_t;

endpackage

// ----- hdl/lr_step.sv -----
// Line state, load setup and per-tick step; registers the emitted pixel.
`timescale 1ns / 1ps

module lr_step #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [COORD_BITS-1:0]        s_start_x,
    input  logic [COORD_BITS-1:0]        s_start_y,
    input  logic [COORD_BITS-1:0]        s_end_x,
    input  logic [COORD_BITS-1:0]        s_end_y,
    input  logic [lr_pkg::COLOR_W-1:0]   s_color,
    input  logic                         pipe_ready,
    output lr_pkg::pix_ctl_t             pix_ctl,
    output logic [COORD_BITS-1:0]        pix_x,
    output logic [COORD_BITS-1:0]        pix_y,
    output logic [lr_pkg::COLOR_W-1:0]   pix_color
);
    import lr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int SW = CW + 1;
    localparam int EW = CW + 2;

    logic [SW-1:0]      cur_x_reg, cur_y_reg;
    logic [CW-1:0]      tgt_x_reg, tgt_y_reg;
    logic [CW-1:0]      span_x_reg, span_y_reg;
    logic [EW-1:0]      err_reg;
    octant_t            oct_reg;
    logic               active_reg;
    logic [COLOR_W-1:0] color_reg;
    pix_ctl_t           ctl_reg;
    logic [CW-1:0]      px_reg, py_reg;

    logic               accept;
    logic               swap;
    logic [CW-1:0]      ax, ay, bx, by;
    logic [CW-1:0]      span_x_ld, span_y_ld;
    logic               left_ld, steep_ld, last_ld, flat_ld;
    logic [SW-1:0]      cur_y_ld;

    logic               neg;
    logic [SW-1:0]      x_step, y_inc, x_tk, y_tk;
    logic [EW-1:0]      sx_e, sy_e, err_diag, err_tk;
    logic               last_tk;

    assign s_ready = !ctl_reg.valid || pipe_ready;
    assign accept  = s_valid && s_ready;

    // load setup: endpoints ordered so the line runs toward larger rows
    always_comb begin
        swap      = s_start_y > s_end_y;
        ax        = swap ? s_end_x   : s_start_x;
        ay        = swap ? s_end_y   : s_start_y;
        bx        = swap ? s_start_x : s_end_x;
        by        = swap ? s_start_y : s_end_y;
        span_y_ld = by - ay;
        left_ld   = bx < ax;
        span_x_ld = left_ld ? (ax - bx) : (bx - ax);
        steep_ld  = span_y_ld > span_x_ld;
        last_ld   = !steep_ld && (span_x_ld == '0);
        flat_ld   = !steep_ld && (span_y_ld == '0);
        cur_y_ld  = flat_ld ? ({1'b0, ay} - SW'(1)) : {1'b0, ay};
    end

    // one step of the active line
    always_comb begin
        neg      = err_reg[EW-1];
        sx_e     = {2'b00, span_x_reg};
        sy_e     = {2'b00, span_y_reg};
        err_diag = err_reg + sy_e - sx_e;
        x_step   = oct_reg[1] ? (cur_x_reg - SW'(1)) : (cur_x_reg + SW'(1));
        y_inc    = cur_y_reg + SW'(1);
        if (!oct_reg[0]) begin
            x_tk    = neg ? x_step : cur_x_reg;
            y_tk    = y_inc;
            err_tk  = neg ? err_diag : (err_reg - sx_e);
            last_tk = y_tk >= {1'b0, tgt_y_reg};
        end else begin
            x_tk    = x_step;
            y_tk    = neg ? cur_y_reg : y_inc;
            err_tk  = neg ? (err_reg + sy_e) : err_diag;
            last_tk = x_tk == {1'b0, tgt_x_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
            err_reg    <= '0;
            oct_reg    <= OCT_STEEP_RIGHT;
            active_reg <= 1'b0;
            color_reg  <= '0;
            ctl_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
        end else if (accept && s_command == CMD_LOAD) begin
            cur_x_reg     <= {1'b0, ax};
            cur_y_reg     <= cur_y_ld;
            tgt_x_reg     <= bx;
            tgt_y_reg     <= by;
            span_x_reg    <= span_x_ld;
            span_y_reg    <= span_y_ld;
            err_reg       <= '0;
            oct_reg       <= octant_t'({left_ld, !steep_ld});
            active_reg    <= !last_ld;
            color_reg     <= s_color;
            ctl_reg.valid <= 1'b1;
            ctl_reg.last  <= last_ld;
            px_reg        <= ax;
            py_reg        <= ay;
        end else if (accept && active_reg) begin
            cur_x_reg     <= x_tk;
            cur_y_reg     <= y_tk;
            err_reg       <= err_tk;
            active_reg    <= !last_tk;
            ctl_reg.valid <= 1'b1;
            ctl_reg.last  <= last_tk;
            px_reg        <= x_tk[CW-1:0];
            py_reg        <= y_tk[CW-1:0];
        end else if (pipe_ready) begin
            ctl_reg.valid <= 1'b0;
        end
    end

    assign pix_ctl   = ctl_reg;
    assign pix_x     = px_reg;
    assign pix_y     = py_reg;
    assign pix_color = color_reg;

endmodule

// ----- hdl/lr_addr.sv -----
// Word offset computation and result output register.
`timescale 1ns / 1ps

module lr_addr #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lr_pkg::pix_ctl_t             pix_ctl,
    input  logic [COORD_BITS-1:0]        pix_x,
    input  logic [COORD_BITS-1:0]        pix_y,
    input  logic [lr_pkg::COLOR_W-1:0]   pix_color,
    input  logic [lr_pkg::STRIDE_W-1:0]  stride,
    output logic                         pipe_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COORD_BITS-1:0]        m_pixel_x,
    output logic [COORD_BITS-1:0]        m_pixel_y,
    output logic [lr_pkg::OFFSET_W-1:0]  m_pixel_offset,
    output logic [lr_pkg::COLOR_W-1:0]   m_pixel_color,
    output logic                         m_last_pixel
);
    import lr_pkg::*;

    localparam int PW = (COORD_BITS + STRIDE_W >= OFFSET_W) ?
                        (COORD_BITS + STRIDE_W) : OFFSET_W;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  last_reg;

    logic [PW-1:0]         prod;
    logic [PW-1:0]         sum;

    assign pipe_ready = !valid_reg || m_ready;

    always_comb begin
        prod = PW'(pix_y) * PW'(stride);
        sum  = prod + PW'(pix_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pipe_ready) begin
            valid_reg <= pix_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready && pix_ctl.valid) begin
            x_reg      <= pix_x;
            y_reg      <= pix_y;
            offset_reg <= sum[OFFSET_W-1:0];
            color_reg  <= pix_color;
            last_reg   <= pix_ctl.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_pixel_x      = x_reg;
    assign m_pixel_y      = y_reg;
    assign m_pixel_offset = offset_reg;
    assign m_pixel_color  = color_reg;
    assign m_last_pixel   = last_reg;

endmodule

// ----- hdl/line_rasterizer.sv -----
// Top level of the line rasterizer: stride register, step stage, offset stage.
//
//  channel   dir  signals                                   transfer when
//  s_        in   command, start/end x/y, color             s_valid & s_ready
//  m_        out  pixel_x/y, pixel_offset/color, last_pixel m_valid & m_ready
//  cfg_      in   cfg_data (line stride)                    cfg_valid & cfg_ready
//
// One input transfer per cycle while s_ready is high; a pixel is registered first
// in the step register, then in the offset multiply register.
// Reset (aresetn low, synchronous) clears the line state; stride goes to 1920.
// A stalled m_ side fills both stages, then s_ready drops.
// cfg_ready is always high.
`timescale 1ns / 1ps

module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [COORD_BITS-1:0]        s_start_x,
    input  logic [COORD_BITS-1:0]        s_start_y,
    input  logic [COORD_BITS-1:0]        s_end_x,
    input  logic [COORD_BITS-1:0]        s_end_y,
    input  logic [lr_pkg::COLOR_W-1:0]   s_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COORD_BITS-1:0]        m_pixel_x,
    output logic [COORD_BITS-1:0]        m_pixel_y,
    output logic [lr_pkg::OFFSET_W-1:0]  m_pixel_offset,
    output logic [lr_pkg::COLOR_W-1:0]   m_pixel_color,
    output logic                         m_last_pixel,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lr_pkg::STRIDE_W-1:0]  cfg_data
);
    import lr_pkg::*;

    logic [STRIDE_W-1:0]   stride_reg;
    pix_ctl_t              pix_ctl;
    logic [COORD_BITS-1:0] pix_x, pix_y;
    logic [COLOR_W-1:0]    pix_color;
    logic                  pipe_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= STRIDE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            stride_reg <= cfg_data;
        end
    end

    lr_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y),
        .s_color   (s_color),
        .pipe_ready(pipe_ready),
        .pix_ctl   (pix_ctl),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_color (pix_color)
    );

    lr_addr #(
        .COORD_BITS(COORD_BITS)
    ) u_addr (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pix_ctl       (pix_ctl),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_color     (pix_color),
        .stride        (stride_reg),
        .pipe_ready    (pipe_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_offset(m_pixel_offset),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

// ----- hdl/lr_checker.sv -----
// Port-level assertions for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`include "line_rasterizer_macros.svh"

module lr_checker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_command,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [COORD_BITS-1:0]        m_pixel_x,
    input logic [COORD_BITS-1:0]        m_pixel_y,
    input logic [lr_pkg::OFFSET_W-1:0]  m_pixel_offset,
    input logic [lr_pkg::COLOR_W-1:0]   m_pixel_color,
    input logic                         m_last_pixel
);
    import lr_pkg::*;

    // a load always yields a pixel at the output, through the step and offset registers
    `LR_ASSERT(a_load_emits, s_valid && s_ready && s_command == CMD_LOAD |-> ##2 m_valid)

    // input side only stalls behind a blocked result
    `LR_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready)

    // blocked result holds
    `LR_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) &&
               $stable(m_pixel_y) && $stable(m_pixel_offset) &&
               $stable(m_pixel_color) && $stable(m_last_pixel))

    `LR_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid)

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
